// File: sv/linear_probe_hash_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Concurrent assertion wrappers that are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpht assertion failed");
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpht assertion failed");
`else
`define LPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Sizes, codes and the interface types shared by the table modules.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int SLOT_COUNT = 256;
	localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
	localparam int COUNT_BITS = SLOT_BITS + 1;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 32;
	localparam int LOAD_LIMIT = SLOT_COUNT * 3 / 4;

	localparam logic [SLOT_BITS-1:0]  SLOT_LAST   = SLOT_BITS'(SLOT_COUNT - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(LOAD_LIMIT);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	localparam logic [1:0] STATUS_FOUND = 2'd0;
	localparam logic [1:0] STATUS_NEW   = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0]  rd_addr;
		logic                  we;
		logic [SLOT_BITS-1:0]  wr_addr;
		logic [KEY_BITS-1:0]   wr_key;
		logic [VALUE_BITS-1:0] wr_value;
	} mem_req_t;

	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} mem_rsp_t;

endpackage

// File: sv/lpht_slot_store.sv
// ----------------------------------------------------------------------------
// Linear probe hash table slot store
// Valid flags in flip-flops plus a key/value memory with a registered read.
// ----------------------------------------------------------------------------
module lpht_slot_store (
	input  logic              clk,
	input  logic              arst_n,
	input  lpht_pkg::mem_req_t req,
	output lpht_pkg::mem_rsp_t rsp
);

	logic [lpht_pkg::SLOT_COUNT-1:0] valid_q;
	logic [lpht_pkg::KEY_BITS-1:0]   key_mem   [lpht_pkg::SLOT_COUNT];
	logic [lpht_pkg::VALUE_BITS-1:0] value_mem [lpht_pkg::SLOT_COUNT];
	logic                            rd_valid_q;
	logic [lpht_pkg::KEY_BITS-1:0]   rd_key_q;
	logic [lpht_pkg::VALUE_BITS-1:0] rd_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			key_mem[req.wr_addr]   <= req.wr_key;
			value_mem[req.wr_addr] <= req.wr_value;
		end
		rd_key_q   <= key_mem[req.rd_addr];
		rd_value_q <= value_mem[req.rd_addr];
	end

	assign rsp.valid = rd_valid_q;
	assign rsp.key   = rd_key_q;
	assign rsp.value = rd_value_q;

endmodule

// File: sv/lpht_probe_ctrl.sv
// ----------------------------------------------------------------------------
// Linear probe hash table probe sequencer
// Walks the slots one per cycle from the home slot and settles each request.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_unit_defines.svh"

module lpht_probe_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            cmd,
	input  logic [lpht_pkg::KEY_BITS-1:0]   key_id,
	input  logic [31:0]                     key_hash,
	input  logic [lpht_pkg::VALUE_BITS-1:0] write_value,
	output logic                            busy,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [lpht_pkg::VALUE_BITS-1:0] read_value,
	output lpht_pkg::mem_req_t              mem_req,
	input  lpht_pkg::mem_rsp_t              mem_rsp
);

	lpht_pkg::state_t                  state_q, state_d;
	logic                              cmd_q;
	logic [lpht_pkg::KEY_BITS-1:0]     key_q;
	logic [lpht_pkg::VALUE_BITS-1:0]   value_q;
	logic [lpht_pkg::SLOT_BITS-1:0]    idx_q;
	logic [lpht_pkg::SLOT_BITS-1:0]    cnt_q;
	logic [lpht_pkg::COUNT_BITS-1:0]   entry_count_q;
	logic                              done_q;
	logic [1:0]                        status_q;
	logic [lpht_pkg::VALUE_BITS-1:0]   read_value_q;

	logic                              accept;
	logic                              hit;
	logic                              empty;
	logic                              finish;
	logic                              insert;
	logic [1:0]                        status_d;
	logic [lpht_pkg::VALUE_BITS-1:0]   read_value_d;

	assign accept = start && (state_q == lpht_pkg::ST_IDLE);
	assign hit    = mem_rsp.valid && (mem_rsp.key == key_q);
	assign empty  = !mem_rsp.valid;
	assign insert = (state_q == lpht_pkg::ST_PROBE) && (cmd_q == lpht_pkg::CMD_SET) &&
		empty && (entry_count_q < lpht_pkg::COUNT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lpht_pkg::ST_IDLE;
			entry_count_q <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (insert) begin
				entry_count_q <= entry_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			key_q   <= key_id;
			value_q <= write_value;
			idx_q   <= key_hash[lpht_pkg::SLOT_BITS-1:0];
			cnt_q   <= '0;
		end else if (state_q == lpht_pkg::ST_PROBE) begin
			idx_q <= idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (finish) begin
			status_q     <= status_d;
			read_value_q <= read_value_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		finish           = 1'b0;
		status_d         = lpht_pkg::STATUS_NEW;
		read_value_d     = '0;
		mem_req.rd_addr  = key_hash[lpht_pkg::SLOT_BITS-1:0];
		mem_req.we       = 1'b0;
		mem_req.wr_addr  = idx_q;
		mem_req.wr_key   = key_q;
		mem_req.wr_value = value_q;
		unique case (state_q)
			lpht_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = lpht_pkg::ST_PROBE;
				end
			end
			lpht_pkg::ST_PROBE: begin
				mem_req.rd_addr = idx_q + 1'b1;
				finish = empty || hit || (cnt_q == lpht_pkg::SLOT_LAST);
				if (finish) begin
					state_d = lpht_pkg::ST_IDLE;
				end
				if (cmd_q == lpht_pkg::CMD_GET) begin
					if (hit) begin
						status_d     = lpht_pkg::STATUS_FOUND;
						read_value_d = mem_rsp.value;
					end
				end else begin
					if (hit) begin
						status_d   = lpht_pkg::STATUS_FOUND;
						mem_req.we = 1'b1;
					end else if (insert) begin
						status_d   = lpht_pkg::STATUS_NEW;
						mem_req.we = 1'b1;
					end else begin
						status_d = lpht_pkg::STATUS_FULL;
					end
				end
			end
			default: begin
				state_d = lpht_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy       = (state_q != lpht_pkg::ST_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;

	// A result strobe lasts a single cycle.
	`LPHT_ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q)
	// An accepted transaction makes the block busy on the next cycle.
	`LPHT_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, busy)
	// An insert never pushes the table past its load limit.
	`LPHT_ASSERT_IMP(a_insert_room, clk, arst_n, insert,
		entry_count_q < lpht_pkg::COUNT_LIMIT)
	// Only a found key returns a nonzero value.
	`LPHT_ASSERT_IMP(a_value_zero, clk, arst_n,
		done_q && (status_q != lpht_pkg::STATUS_FOUND), read_value_q == '0)
	// A write only happens when a probe ends.
	`LPHT_ASSERT_IMP(a_write_finish, clk, arst_n, mem_req.we, finish)

endmodule

// File: sv/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressing key/value table with linear probing and a 3/4 load limit.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload
// request   start, busy         cmd, key_id, key_hash, write_value
// result    done (strobe)       status, read_value
//
// A transaction probes one slot per cycle through the single memory read port.
// The result strobe is registered from the last probe, after 1 up to 256 slots,
// and the next request is taken at the edge that ends the strobe cycle, so the
// block takes no new request while a transaction is probing. Reset clears all
// valid flags and the entry count at once. The result is shown for one cycle
// and cannot be stalled.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            cmd,
	input  logic [lpht_pkg::KEY_BITS-1:0]   key_id,
	input  logic [31:0]                     key_hash,
	input  logic [lpht_pkg::VALUE_BITS-1:0] write_value,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [lpht_pkg::VALUE_BITS-1:0] read_value
);

	lpht_pkg::mem_req_t mem_req;
	lpht_pkg::mem_rsp_t mem_rsp;

	lpht_probe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.key_id      (key_id),
		.key_hash    (key_hash),
		.write_value (write_value),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.mem_req     (mem_req),
		.mem_rsp     (mem_rsp)
	);

	lpht_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table unit testbench
// Drives get and set requests through the start/busy handshake and checks
// every result strobe against a table model kept in the testbench. The run
// covers an empty table, probe wrap at the last slot, updates, misses that
// end on an empty slot, the 3/4 load limit and a long random mix of requests.
// ----------------------------------------------------------------------------
module testbench;

	localparam int POOL_SIZE   = 256;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = lpht_pkg::SLOT_COUNT + 44;

	typedef struct {
		logic                            op;
		logic [lpht_pkg::KEY_BITS-1:0]   key;
		logic [1:0]                      status;
		logic [lpht_pkg::VALUE_BITS-1:0] value;
	} reply_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            cmd;
	logic [lpht_pkg::KEY_BITS-1:0]   key_id;
	logic [31:0]                     key_hash;
	logic [lpht_pkg::VALUE_BITS-1:0] write_value;
	logic                            done;
	logic [1:0]                      status;
	logic [lpht_pkg::VALUE_BITS-1:0] read_value;

	logic                            model_valid [lpht_pkg::SLOT_COUNT];
	logic [lpht_pkg::KEY_BITS-1:0]   model_key   [lpht_pkg::SLOT_COUNT];
	logic [lpht_pkg::VALUE_BITS-1:0] model_value [lpht_pkg::SLOT_COUNT];
	int                              model_entries;

	logic [lpht_pkg::KEY_BITS-1:0] pool_key  [POOL_SIZE];
	logic [31:0]                   pool_hash [POOL_SIZE];

	reply_t pending_replies [$];
	reply_t head_reply;

	int  error_count   = 0;
	int  request_count = 0;
	int  reply_count   = 0;
	int  cycle_count   = 0;
	int  gets_found    = 0;
	int  gets_missing  = 0;
	int  sets_updated  = 0;
	int  sets_inserted = 0;
	int  sets_refused  = 0;
	int  longest_probe = 0;
	bit  burst_mode    = 1'b0;

	linear_probe_hash_table_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.key_id     (key_id),
		.key_hash   (key_hash),
		.write_value(write_value),
		.done       (done),
		.status     (status),
		.read_value (read_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic reply_t apply_request(logic op, logic [lpht_pkg::KEY_BITS-1:0] key,
			logic [31:0] hash, logic [lpht_pkg::VALUE_BITS-1:0] value);
		reply_t r;
		int     idx;
		int     probes;
		bit     hit;
		bit     empty_seen;
		r.op       = op;
		r.key      = key;
		r.status   = lpht_pkg::STATUS_NEW;
		r.value    = '0;
		idx        = int'(hash[lpht_pkg::SLOT_BITS-1:0]);
		probes     = 0;
		hit        = 1'b0;
		empty_seen = 1'b0;
		while (probes < lpht_pkg::SLOT_COUNT && !hit && !empty_seen) begin
			probes++;
			if (!model_valid[idx])
				empty_seen = 1'b1;
			else if (model_key[idx] == key)
				hit = 1'b1;
			else
				idx = (idx + 1) % lpht_pkg::SLOT_COUNT;
		end
		if (probes > longest_probe)
			longest_probe = probes;
		if (op == lpht_pkg::CMD_GET) begin
			if (hit) begin
				r.status = lpht_pkg::STATUS_FOUND;
				r.value  = model_value[idx];
				gets_found++;
			end else begin
				gets_missing++;
			end
		end else if (hit) begin
			model_value[idx] = value;
			r.status = lpht_pkg::STATUS_FOUND;
			sets_updated++;
		end else if (empty_seen &&
				(model_entries + 1) * 4 <= lpht_pkg::SLOT_COUNT * 3) begin
			model_valid[idx] = 1'b1;
			model_key[idx]   = key;
			model_value[idx] = value;
			model_entries++;
			sets_inserted++;
		end else begin
			r.status = lpht_pkg::STATUS_FULL;
			sets_refused++;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] make_hash();
		logic [31:0] h;
		h = $urandom;
		case ($urandom_range(0, 2))
			0: h[7:0] = 8'($urandom_range(248, 255));
			1: h[7:0] = 8'($urandom_range(64, 79));
			default: ;
		endcase
		return h;
	endfunction

	task automatic report_mismatch(input string what, input reply_t want,
			input logic [31:0] got, input logic [31:0] expected);
		$display("[%0t] mismatch in %s (op %0b key %h): got %h expected %h",
			$realtime, what, want.op, want.key, got, expected);
		error_count++;
	endtask

	task automatic send_request(input logic op, input logic [lpht_pkg::KEY_BITS-1:0] key,
			input logic [31:0] hash, input logic [lpht_pkg::VALUE_BITS-1:0] value);
		int gap;
		cmd         <= op;
		key_id      <= key;
		key_hash    <= hash;
		write_value <= value;
		start       <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_replies.push_back(apply_request(op, key, hash, value));
		request_count++;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_replies.size() != 0);
	endtask

	task automatic send_pool_item(input int top);
		int r;
		int idx;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			send_request(1'($urandom_range(0, 1)), 16'($urandom), $urandom, $urandom);
		end else begin
			idx = $urandom_range(0, top);
			send_request(r < 56 ? lpht_pkg::CMD_GET : lpht_pkg::CMD_SET, pool_key[idx],
				pool_hash[idx], $urandom);
		end
	endtask

	task automatic build_key_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_key[i]  = 16'($urandom);
			pool_hash[i] = make_hash();
		end
	endtask

	task automatic test_empty_table();
		send_request(lpht_pkg::CMD_GET, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(lpht_pkg::CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
	endtask

	task automatic test_wrap_and_update();
		send_request(lpht_pkg::CMD_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lpht_pkg::CMD_SET, 16'h0000, 32'h0000_00FF, 32'h0000_0000);
		send_request(lpht_pkg::CMD_SET, 16'h8001, 32'h8000_00FF, 32'hA5A5_A5A5);
		send_request(lpht_pkg::CMD_GET, 16'h0000, 32'h0000_00FF, 32'h1234_5678);
		send_request(lpht_pkg::CMD_GET, 16'h8001, 32'h8000_00FF, 32'h0000_0000);
		send_request(lpht_pkg::CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lpht_pkg::CMD_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		send_request(lpht_pkg::CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lpht_pkg::CMD_GET, 16'h1234, 32'h0000_00FF, 32'h0000_0000);
		send_request(lpht_pkg::CMD_GET, 16'h8001, 32'h0000_0001, 32'h0000_0000);
		send_request(lpht_pkg::CMD_SET, 16'h5A5A, 32'h7FFF_FF00, 32'h5A5A_5A5A);
		send_request(lpht_pkg::CMD_GET, 16'h5A5A, 32'h0000_0000, 32'h0000_0000);
		wait_for_drain();
		send_request(lpht_pkg::CMD_SET, 16'h0000, 32'h0000_00FF, 32'hFFFF_FFFF);
		send_request(lpht_pkg::CMD_GET, 16'h0000, 32'h0000_00FF, 32'h0000_0000);
	endtask

	task automatic test_random_mix();
		int top;
		build_key_pool();
		for (int i = 0; i < 800; i++) begin
			if (i % 64 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			if (i % 150 == 149)
				wait_for_drain();
			top = i / 4 + 8;
			if (top > POOL_SIZE - 1)
				top = POOL_SIZE - 1;
			send_pool_item(top);
		end
		burst_mode = 1'b0;
	endtask

	task automatic test_load_limit();
		while (model_entries < lpht_pkg::LOAD_LIMIT) begin
			if ($urandom_range(0, 3) == 0)
				send_request(lpht_pkg::CMD_GET, 16'($urandom), make_hash(), $urandom);
			send_request(lpht_pkg::CMD_SET, 16'($urandom), make_hash(), $urandom);
		end
		for (int i = 0; i < 8; i++)
			send_request(lpht_pkg::CMD_SET, 16'($urandom), make_hash(), $urandom);
		send_request(lpht_pkg::CMD_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
		send_request(lpht_pkg::CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(lpht_pkg::CMD_GET, 16'h1234, 32'h0000_00FF, 32'h0000_0000);
		wait_for_drain();
	endtask

	task automatic test_random_full();
		for (int i = 0; i < 300; i++) begin
			if (i % 50 == 0)
				burst_mode = ($urandom_range(0, 2) == 0);
			send_pool_item(POOL_SIZE - 1);
		end
		burst_mode = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			reply_count++;
			if (pending_replies.size() == 0) begin
				head_reply.op  = cmd;
				head_reply.key = key_id;
				report_mismatch("unexpected result", head_reply, {30'd0, status}, 32'd0);
			end else begin
				head_reply = pending_replies.pop_front();
				if (status !== head_reply.status)
					report_mismatch("status", head_reply, {30'd0, status},
						{30'd0, head_reply.status});
				if (read_value !== head_reply.value)
					report_mismatch("read_value", head_reply, read_value, head_reply.value);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_replies.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = lpht_pkg::CMD_GET;
		key_id      = '0;
		key_hash    = '0;
		write_value = '0;
		model_entries = 0;
		foreach (model_valid[i]) begin
			model_valid[i] = 1'b0;
			model_key[i]   = '0;
			model_value[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_wrap_and_update();
		test_random_mix();
		test_load_limit();
		test_random_full();

		wait_for_drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d requests and checked %0d results; longest probe %0d slots.",
			request_count, reply_count, longest_probe);
		$display("Gets found %0d, missing %0d; sets updated %0d, inserted %0d, refused %0d.",
			gets_found, gets_missing, sets_updated, sets_inserted, sets_refused);
		if (error_count == 0 && pending_replies.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results never seen", error_count,
				pending_replies.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_slot_store.sv
sv/lpht_probe_ctrl.sv
sv/linear_probe_hash_table_unit.sv
tb/testbench.sv
